>>> hw/rtl/hpec_pkg.sv
// Shared types and constants of the high-pass emphasis coefficient block.
`default_nettype none

package hpec_pkg;

	localparam int IDX_W   = 10;  // row / column index
	localparam int STEP_W  = 24;  // Q2.22 step
	localparam int PROD_W  = IDX_W + STEP_W;
	localparam int COORD_W = 24;  // Q3.21 coordinate
	localparam int SQ_W    = 2 * COORD_W - 1;  // one squared coordinate
	localparam int R2_W    = SQ_W + 1;         // sum of two squares
	localparam int ROOT_W  = 25;               // floor square root, Q4.21
	localparam int ANG_W   = 22;               // reduced angle, Q1.21
	localparam int T_W     = 31;               // angle, Q1.30
	localparam int ACC_W   = 31;               // Horner accumulator, Q1.30
	localparam int P_W     = 32;               // product after >> 30
	localparam int COEF_W  = 16;

	localparam logic [STEP_W-1:0] STEP_RESET  = 24'd12881;
	localparam logic [PROD_W:0]   HALF_PI_Q22 = 35'd6588397;
	localparam logic [COORD_W-1:0] PI_Q21      = 24'd6588397;
	localparam logic [COORD_W-1:0] HALF_PI_Q21 = 24'd3294198;
	localparam logic [ACC_W-1:0]   Q30_ONE     = 31'h4000_0000;
	localparam logic [COEF_W-1:0]  COEF_ONE    = 16'd32768;

	// Horner divisors of the sine series, innermost first
	localparam int HORNER_N = 5;
	localparam logic [6:0] HORNER_DIV [HORNER_N] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};

	typedef enum logic {
		REG_ROW_STEP = 1'b0,
		REG_COL_STEP = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

>>> hw/rtl/hpec_coord.sv
// Coordinate stages: index times step, minus pi/2, to saturated Q3.21.
`default_nettype none

module hpec_coord
	import hpec_pkg::*;
#(
	parameter int MAX_DIM = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vld_in,
	input  wire logic [IDX_W-1:0]           row_index,
	input  wire logic [IDX_W-1:0]           col_index,
	input  wire logic [STEP_W-1:0]          row_step,
	input  wire logic [STEP_W-1:0]          col_step,
	output logic                            vld_out,
	output logic signed [COORD_W-1:0]       y_out,
	output logic signed [COORD_W-1:0]       x_out
);

	logic [IDX_W-1:0]  row_c, col_c;
	logic [PROD_W-1:0] y_prod_s1, x_prod_s1;
	logic              vld_s1;

	function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
		if (32'(idx) > MAX_DIM - 1)
			return IDX_W'(MAX_DIM - 1);
		return idx;
	endfunction

	// floor((c22 + 1) / 2), held to the Q3.21 range
	function automatic logic signed [COORD_W-1:0] to_q21(input logic [PROD_W-1:0] prod);
		logic signed [PROD_W+1:0] c22;
		logic signed [PROD_W+1:0] c21;
		c22 = $signed({2'b00, prod}) - $signed({1'b0, HALF_PI_Q22});
		c21 = (c22 + (PROD_W+2)'(1)) >>> 1;
		if (c21 > $signed((PROD_W+2)'(8388607)))
			return COORD_W'(24'h7F_FFFF);
		if (c21 < -$signed((PROD_W+2)'(8388608)))
			return COORD_W'(24'h80_0000);
		return c21[COORD_W-1:0];
	endfunction

	assign row_c = clamp_idx(row_index);
	assign col_c = clamp_idx(col_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_in;
			vld_out <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_prod_s1 <= PROD_W'(row_c) * PROD_W'(row_step);
			x_prod_s1 <= PROD_W'(col_c) * PROD_W'(col_step);
			y_out     <= to_q21(y_prod_s1);
			x_out     <= to_q21(x_prod_s1);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/hpec_radius.sv
// Radius stages: squares, sum, bit-per-stage square root, reduction to [0, pi/2].
`default_nettype none

module hpec_radius
	import hpec_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    vld_in,
	input  wire logic signed [COORD_W-1:0] y_in,
	input  wire logic signed [COORD_W-1:0] x_in,
	output logic                         vld_out,
	output logic [T_W-1:0]               t_out
);

	localparam int SQ_N = ROOT_W;  // root bits, one per stage
	localparam int RT_W = R2_W + 2;

	logic              vld_s1, vld_s2;
	logic [SQ_W-1:0]   ysq_s1, xsq_s1;
	logic [R2_W-1:0]   r2_s2;
	logic [COORD_W*2-1:0] ysq_full, xsq_full;

	logic              sq_vld_s [0:SQ_N];
	logic [R2_W-1:0]   sq_rem_s [0:SQ_N];
	logic [RT_W-1:0]   sq_root_s [0:SQ_N];

	logic [COORD_W-1:0] r_w, m_w, fold_w;

	assign ysq_full = (COORD_W*2)'($signed(y_in) * $signed(y_in));
	assign xsq_full = (COORD_W*2)'($signed(x_in) * $signed(x_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ysq_s1 <= ysq_full[SQ_W-1:0];
			xsq_s1 <= xsq_full[SQ_W-1:0];
			r2_s2  <= R2_W'(ysq_s1) + R2_W'(xsq_s1);
		end
	end

	assign sq_vld_s[0]  = vld_s2;
	assign sq_rem_s[0]  = r2_s2;
	assign sq_root_s[0] = '0;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (SQ_N - 1 - k));
		logic [RT_W-1:0] trial;
		assign trial = sq_root_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_vld_s[k+1] <= 1'b0;
			else if (en)
				sq_vld_s[k+1] <= sq_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (RT_W'(sq_rem_s[k]) >= trial) begin
					sq_rem_s[k+1]  <= sq_rem_s[k] - trial[R2_W-1:0];
					sq_root_s[k+1] <= (sq_root_s[k] >> 1) + BIT;
				end else begin
					sq_rem_s[k+1]  <= sq_rem_s[k];
					sq_root_s[k+1] <= sq_root_s[k] >> 1;
				end
			end
		end
	end

	// radius < 2*pi, so one subtract covers the modulo
	assign r_w    = sq_root_s[SQ_N][COORD_W-1:0];
	assign m_w    = (r_w >= PI_Q21) ? r_w - PI_Q21 : r_w;
	assign fold_w = (m_w > HALF_PI_Q21) ? PI_Q21 - m_w : m_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out <= 1'b0;
		else if (en)
			vld_out <= sq_vld_s[SQ_N];
	end

	always_ff @(posedge clk) begin
		if (en)
			t_out <= {fold_w[ANG_W-1:0], 9'd0};
	end

endmodule

`default_nettype wire

>>> hw/rtl/hpec_sine.sv
// Sine stages: Horner series in Q1.30, squaring and Q1.15 rounding.
`default_nettype none

module hpec_sine
	import hpec_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld_in,
	input  wire logic [T_W-1:0]    t_in,
	output logic                   vld_out,
	output logic [COEF_W-1:0]      coefficient
);

	localparam int ST_N = 3 * HORNER_N;

	logic [2*T_W-1:0] tt_full;
	logic             vld_s1;
	logic [T_W-1:0]   t_s1;
	logic [P_W-1:0]   t2_s1;

	// per Horner step: a = t2*acc, b = times reciprocal, c = correct and update
	logic             hv_s  [0:ST_N];
	logic [T_W-1:0]   ht_s  [0:ST_N];
	logic [P_W-1:0]   ht2_s [0:ST_N];
	logic [ACC_W-1:0] hacc_s[0:ST_N];
	logic [P_W-1:0]   hp_s  [0:ST_N];
	logic [P_W-1:0]   hq_s  [0:ST_N];

	logic             vld_s2, vld_s3;
	logic [T_W-1:0]   s_s2;
	logic [P_W-1:0]   s2_s3;
	logic [T_W+ACC_W-1:0] sa_full;
	logic [2*T_W-1:0] ss_full;
	logic [P_W:0]     rnd_w;
	logic [17:0]      q_w;

	assign tt_full = t_in * t_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= t_in;
			t2_s1 <= tt_full[P_W+29:30];
		end
	end

	assign hv_s[0]   = vld_s1;
	assign ht_s[0]   = t_s1;
	assign ht2_s[0]  = t2_s1;
	assign hacc_s[0] = Q30_ONE;
	assign hp_s[0]   = '0;
	assign hq_s[0]   = '0;

	for (genvar i = 0; i < ST_N; i++) begin : g_horner
		localparam int J = i / 3;
		localparam int PH = i % 3;
		localparam logic [6:0]     K   = HORNER_DIV[J];
		localparam logic [P_W-1:0] RCP = P_W'(64'h1_0000_0000 / 64'(K));

		logic [P_W+ACC_W-1:0] pa_full;
		logic [2*P_W-1:0]     pm_full;
		logic [P_W-1:0]       rem;
		logic [P_W-1:0]       q_fix;
		logic [P_W-1:0]       acc_nx;

		assign pa_full = (P_W+ACC_W)'(ht2_s[i]) * (P_W+ACC_W)'(hacc_s[i]);
		assign pm_full = (2*P_W)'(hp_s[i]) * (2*P_W)'(RCP);
		assign rem     = hp_s[i] - P_W'(hq_s[i] * P_W'(K));
		assign q_fix   = (rem >= P_W'(K)) ? hq_s[i] + P_W'(1) : hq_s[i];
		assign acc_nx  = P_W'(Q30_ONE) - q_fix;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				hv_s[i+1] <= 1'b0;
			else if (en)
				hv_s[i+1] <= hv_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ht_s[i+1]  <= ht_s[i];
				ht2_s[i+1] <= ht2_s[i];
				case (PH)
					0: begin
						hacc_s[i+1] <= hacc_s[i];
						hp_s[i+1]   <= pa_full[P_W+29:30];
						hq_s[i+1]   <= hq_s[i];
					end
					1: begin
						hacc_s[i+1] <= hacc_s[i];
						hp_s[i+1]   <= hp_s[i];
						hq_s[i+1]   <= pm_full[2*P_W-1:P_W];
					end
					default: begin
						hacc_s[i+1] <= acc_nx[ACC_W-1:0];
						hp_s[i+1]   <= hp_s[i];
						hq_s[i+1]   <= hq_s[i];
					end
				endcase
			end
		end
	end

	assign sa_full = (T_W+ACC_W)'(ht_s[ST_N]) * (T_W+ACC_W)'(hacc_s[ST_N]);
	assign ss_full = s_s2 * s_s2;
	assign rnd_w   = (P_W+1)'(s2_s3) + (P_W+1)'(1 << 14);
	assign q_w     = rnd_w[P_W:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s2  <= hv_s[ST_N];
			vld_s3  <= vld_s2;
			vld_out <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2        <= sa_full[T_W+29:30];
			s2_s3       <= ss_full[P_W+29:30];
			coefficient <= (q_w > 18'(COEF_ONE)) ? COEF_ONE : q_w[COEF_W-1:0];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/highpass_emphasis_coefficient.sv
// Top level of the high-pass emphasis coefficient pipeline.
`default_nettype none

// For each (row, column) transaction the block returns sin^2(r) = 1 - cos^2(r) in
// unsigned Q1.15 (32768 = 1.0), where r is the distance from the origin of
// y = -pi/2 + row*row_step and x = -pi/2 + col*col_step (steps in Q2.22,
// coordinates saturated to Q3.21). Rate: one transaction per clock while the output
// side does not stall. Stages from input accept to the output register:
// 2 coordinate stages, 2 square/sum stages, 25 square-root stages, one
// reduction stage, 19 sine stages. The whole pipeline moves on one enable,
// which is high while the output register is empty or being taken, so a stall
// on the output side holds every stage in place. Indices of MAX_DIM or above
// are held at MAX_DIM - 1. Program row_step and col_step only while no
// transaction is in flight; writes to other indices are dropped.
module highpass_emphasis_coefficient
	import hpec_pkg::*;
#(
	parameter int MAX_DIM = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [23:0]       s_axis_tdata,  // [9:0] row_index, [19:10] col_index
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [15:0]            m_axis_tdata,  // [15:0] coefficient
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [STEP_W-1:0] cfg_data
);

	logic [STEP_W-1:0] row_step_q, col_step_q;
	logic              en;
	logic              c_vld, r_vld;
	logic signed [COORD_W-1:0] y_c, x_c;
	logic [T_W-1:0]    t_r;

	// single pipeline advance
	assign en            = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_step_q <= STEP_RESET;
			col_step_q <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_STEP: row_step_q <= cfg_data;
				REG_COL_STEP: col_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hpec_coord #(
		.MAX_DIM(MAX_DIM)
	) u_coord (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (s_axis_tvalid),
		.row_index(s_axis_tdata[9:0]),
		.col_index(s_axis_tdata[19:10]),
		.row_step (row_step_q),
		.col_step (col_step_q),
		.vld_out  (c_vld),
		.y_out    (y_c),
		.x_out    (x_c)
	);

	hpec_radius u_radius (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_in (c_vld),
		.y_in   (y_c),
		.x_in   (x_c),
		.vld_out(r_vld),
		.t_out  (t_r)
	);

	hpec_sine u_sine (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_in     (r_vld),
		.t_in       (t_r),
		.vld_out    (m_axis_tvalid),
		.coefficient(m_axis_tdata)
	);

endmodule

`default_nettype wire

>>> hw/rtl/hpec_checker.sv
// Port-level checks of the coefficient block, bound to the top level.
`default_nettype none

module hpec_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	a_reset_clears: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid right after reset");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= 16'd32768)
		else $error("coefficient above 1.0");

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready not tied to output slot");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind highpass_emphasis_coefficient hpec_checker u_hpec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
